@@ rtl/wave_stream_sample_decoder_core_macros.svh @@
// assertion macros for the wave stream sample decoder rtl
// expects clk and active-low rst_n in the including module
`ifndef WAVE_STREAM_SAMPLE_DECODER_CORE_MACROS_SVH
`define WAVE_STREAM_SAMPLE_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wsd_pkg.sv @@
// shared types and constants for the wave stream sample decoder
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

  // result kinds
  localparam logic [1:0] RES_HEADER = 2'd0;
  localparam logic [1:0] RES_SAMPLE = 2'd1;
  localparam logic [1:0] RES_FAULT  = 2'd2;

  // sample kinds
  localparam logic [1:0] KIND_U8  = 2'd0;
  localparam logic [1:0] KIND_S16 = 2'd1;
  localparam logic [1:0] KIND_S24 = 2'd2;
  localparam logic [1:0] KIND_F32 = 2'd3;

  // fault codes
  localparam logic [2:0] FLT_NOT_RIFF   = 3'd0;
  localparam logic [2:0] FLT_NOT_WAVE   = 3'd1;
  localparam logic [2:0] FLT_PCM_BITS   = 3'd2;
  localparam logic [2:0] FLT_ORG        = 3'd3;
  localparam logic [2:0] FLT_FLOAT_BITS = 3'd4;
  localparam logic [2:0] FLT_CODEC      = 3'd5;
  localparam logic [2:0] FLT_NO_FMT     = 3'd6;

  // little-endian chunk tags
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] CODEC_PCM   = 16'h0001;
  localparam logic [15:0] CODEC_FLOAT = 16'h0003;

  // byte positions inside headers
  localparam logic [4:0] POS_WORD_LAST = 5'd3;
  localparam logic [4:0] POS_CHDR_LAST = 5'd7;
  localparam logic [4:0] POS_FMT_LAST  = 5'd15;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_HDR    = 2'd1,
    EMIT_SAMPLE = 2'd2,
    EMIT_FAULT  = 2'd3
  } emit_op_t;

  // controller to datapath
  typedef struct packed {
    logic       ld_tag;
    logic       ld_len;
    logic       fmt_wr;
    logic [4:0] byte_pos;
    logic       fmt_commit;
    logic       skip_ld_fmt;
    logic       skip_ld_other;
    logic       skip_dec;
    logic       div_len;
    logic       div_frames;
    logic       left_ld;
    logic       left_dec;
    emit_op_t   emit;
    logic [2:0] fault_code;
  } wsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic       riff_ok;
    logic       wave_ok;
    logic       tag_fmt;
    logic       tag_data;
    logic       no_format;
    logic       fmt_bad;
    logic [2:0] fmt_code;
    logic       skip_fmt_zero;
    logic       skip_other_zero;
    logic       skip_last;
    logic       div_idle;
    logic       left_zero;
    logic       left_last;
    logic [2:0] sample_bytes;
  } wsd_sts_t;

endpackage

@@ rtl/wsd_datapath.sv @@
// datapath: byte assembly, format registers, skip and sample counters,
// serial divider and output register; depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_datapath
  import wsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   in_data_byte,
  input  logic         in_start_of_file,
  input  wsd_cmd_t     cmd,
  output wsd_sts_t     sts,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [1:0]   out_result_kind,
  output logic [1:0]   out_sample_kind,
  output logic [15:0]  out_channels,
  output logic [31:0]  out_frames_per_second,
  output logic [31:0]  out_total_frames,
  output logic signed [31:0] out_normalized_sample,
  output logic [31:0]  out_float_bits,
  output logic         out_final_sample,
  output logic [2:0]   out_fault_code
);

  // even rounding in 33 bits, optional minus 16, saturate to 32 bits
  function automatic logic [31:0] even_skip(input logic [31:0] len, input logic sub16);
    logic [32:0] r;
    logic [32:0] d;
    r = ({1'b0, len} + 33'd1) & ~33'd1;
    if (sub16) d = (r > 33'd16) ? (r - 33'd16) : 33'd0;
    else d = r;
    even_skip = d[32] ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // round(n * 2^31 / (2^k - 1)) - 2^30 from the repeated bit pattern of n
  function automatic logic [31:0] norm_q30(input logic [31:0] rep);
    logic [31:0] q;
    q = {1'b0, rep[31:1]} + {31'd0, rep[0]};
    norm_q30 = q - 32'h4000_0000;
  endfunction

  logic [31:0] asm_r, tag_r, len_r, skip_r, rate_r, left_r;
  logic [15:0] codec_r, chan_r, fbytes_r, sbits_r;
  logic [1:0]  fmt_r;
  logic [2:0]  sbytes_r;
  logic [31:0] asm_nxt;

  logic        div_busy_r;
  logic [5:0]  div_cnt_r;
  logic [15:0] div_rem_r, div_dvs_r;
  logic [31:0] div_quo_r;
  logic [16:0] div_shift;
  logic        div_bit;

  logic        out_valid_r;
  logic [1:0]  res_kind_r, smp_kind_r;
  logic [15:0] chan_out_r;
  logic [31:0] rate_out_r, total_r, norm_r, float_r;
  logic        final_r;
  logic [2:0]  fault_r;

  assign asm_nxt = {in_data_byte, asm_r[31:8]};

  // byte assembly and chunk header capture
  always_ff @(posedge clk) begin
    if (accept) asm_r <= asm_nxt;
    if (cmd.ld_tag) tag_r <= asm_nxt;
    if (cmd.ld_len) len_r <= asm_nxt;
  end

  // fmt body fields
  always_ff @(posedge clk) begin
    if (cmd.fmt_wr) begin
      unique case (cmd.byte_pos)
        5'd0:  codec_r[7:0]   <= in_data_byte;
        5'd1:  codec_r[15:8]  <= in_data_byte;
        5'd2:  chan_r[7:0]    <= in_data_byte;
        5'd3:  chan_r[15:8]   <= in_data_byte;
        5'd4:  rate_r[7:0]    <= in_data_byte;
        5'd5:  rate_r[15:8]   <= in_data_byte;
        5'd6:  rate_r[23:16]  <= in_data_byte;
        5'd7:  rate_r[31:24]  <= in_data_byte;
        5'd12: fbytes_r[7:0]  <= in_data_byte;
        5'd13: fbytes_r[15:8] <= in_data_byte;
        5'd14: sbits_r[7:0]   <= in_data_byte;
        5'd15: sbits_r[15:8]  <= in_data_byte;
        default: ;
      endcase
    end
  end

  // format check on the completed fmt body
  logic [15:0] sbits_full;
  logic [1:0]  chk_kind;
  logic [2:0]  chk_nb;
  logic        chk_bad;
  logic [2:0]  chk_code;
  logic [17:0] nbch;
  logic [18:0] nbch_hi;

  assign sbits_full = {in_data_byte, sbits_r[7:0]};

  always_comb begin
    chk_kind = KIND_S16;
    chk_nb   = 3'd2;
    chk_bad  = 1'b0;
    chk_code = FLT_CODEC;
    nbch     = 18'd0;
    nbch_hi  = 19'd0;
    if (codec_r == CODEC_PCM) begin
      if (sbits_full == 16'd8) begin
        chk_kind = KIND_U8;
        chk_nb   = 3'd1;
      end else if (sbits_full <= 16'd16) begin
        chk_kind = KIND_S16;
        chk_nb   = 3'd2;
      end else if (sbits_full <= 16'd24) begin
        chk_kind = KIND_S24;
        chk_nb   = 3'd3;
      end else begin
        chk_bad  = 1'b1;
        chk_code = FLT_PCM_BITS;
      end
      // frame_bytes / channels == nb  <=>  nb*ch <= fb < nb*ch + ch
      nbch    = {2'd0, chan_r} * {16'd0, chk_nb[1:0]};
      nbch_hi = {1'b0, nbch} + {3'd0, chan_r};
      if (!chk_bad && (chan_r == 16'd0 || {2'd0, fbytes_r} < nbch ||
                       {3'd0, fbytes_r} >= nbch_hi)) begin
        chk_bad  = 1'b1;
        chk_code = FLT_ORG;
      end
    end else if (codec_r == CODEC_FLOAT) begin
      chk_kind = KIND_F32;
      chk_nb   = 3'd4;
      if (sbits_full != 16'd32) begin
        chk_bad  = 1'b1;
        chk_code = FLT_FLOAT_BITS;
      end
    end else begin
      chk_bad  = 1'b1;
      chk_code = FLT_CODEC;
    end
  end

  // sample format, cleared by a new file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbytes_r <= 3'd0;
      fmt_r    <= KIND_U8;
    end else if (accept && in_start_of_file) begin
      sbytes_r <= 3'd0;
      fmt_r    <= KIND_U8;
    end else if (cmd.fmt_commit) begin
      sbytes_r <= chk_nb;
      fmt_r    <= chk_kind;
    end
  end

  // skip counter
  logic [31:0] skip_fmt_val, skip_other_val;
  assign skip_fmt_val   = even_skip(len_r, 1'b1);
  assign skip_other_val = even_skip(asm_nxt, 1'b0);

  always_ff @(posedge clk) begin
    if (cmd.skip_ld_fmt) skip_r <= skip_fmt_val;
    else if (cmd.skip_ld_other) skip_r <= skip_other_val;
    else if (cmd.skip_dec) skip_r <= skip_r - 32'd1;
  end

  // serial restoring divider, one quotient bit per cycle
  assign div_shift = {div_rem_r, div_quo_r[31]};
  assign div_bit   = (div_shift >= {1'b0, div_dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= 6'd0;
    end else if (cmd.div_len || cmd.div_frames) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 6'd32;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 6'd1;
      if (div_cnt_r == 6'd1) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_len) begin
      div_quo_r <= asm_nxt;
      div_dvs_r <= {13'd0, sbytes_r};
      div_rem_r <= 16'd0;
    end else if (cmd.div_frames) begin
      div_quo_r <= div_quo_r;
      div_dvs_r <= chan_r;
      div_rem_r <= 16'd0;
    end else if (div_busy_r) begin
      div_quo_r <= {div_quo_r[30:0], div_bit};
      div_rem_r <= div_bit ? 16'(div_shift - {1'b0, div_dvs_r}) : div_shift[15:0];
    end
  end

  // samples left in the data chunk
  always_ff @(posedge clk) begin
    if (cmd.left_ld) left_r <= div_quo_r;
    else if (cmd.left_dec) left_r <= left_r - 32'd1;
  end

  // sample decode from the word including this byte
  logic [31:0] smp_norm, smp_float;
  always_comb begin
    smp_norm  = 32'd0;
    smp_float = 32'd0;
    case (fmt_r)
      KIND_U8:  smp_norm = norm_q30({4{asm_nxt[31:24]}});
      KIND_S16: smp_norm = norm_q30({2{asm_nxt[31:16] ^ 16'h8000}});
      KIND_S24: smp_norm = norm_q30({asm_nxt[31:8] ^ 24'h80_0000,
                                     asm_nxt[31:24] ^ 8'h80});
      default:  smp_float = asm_nxt;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit != EMIT_NONE) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      smp_kind_r <= KIND_U8;
      chan_out_r <= 16'd0;
      rate_out_r <= 32'd0;
      total_r    <= 32'd0;
      norm_r     <= 32'd0;
      float_r    <= 32'd0;
      final_r    <= 1'b0;
      fault_r    <= FLT_NOT_RIFF;
      unique case (cmd.emit)
        EMIT_HDR: begin
          res_kind_r <= RES_HEADER;
          smp_kind_r <= fmt_r;
          chan_out_r <= chan_r;
          rate_out_r <= rate_r;
          total_r    <= (chan_r == 16'd0) ? 32'd0 : div_quo_r;
        end
        EMIT_SAMPLE: begin
          res_kind_r <= RES_SAMPLE;
          smp_kind_r <= fmt_r;
          norm_r     <= smp_norm;
          float_r    <= smp_float;
          final_r    <= (left_r == 32'd1);
        end
        default: begin
          res_kind_r <= RES_FAULT;
          fault_r    <= cmd.fault_code;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = res_kind_r;
  assign out_sample_kind       = smp_kind_r;
  assign out_channels          = chan_out_r;
  assign out_frames_per_second = rate_out_r;
  assign out_total_frames      = total_r;
  assign out_normalized_sample = norm_r;
  assign out_float_bits        = float_r;
  assign out_final_sample      = final_r;
  assign out_fault_code        = fault_r;

  // status to the controller
  always_comb begin
    sts.out_free        = !out_valid_r || out_ready;
    sts.riff_ok         = (asm_nxt == TAG_RIFF);
    sts.wave_ok         = (asm_nxt == TAG_WAVE);
    sts.tag_fmt         = (tag_r == TAG_FMT);
    sts.tag_data        = (tag_r == TAG_DATA);
    sts.no_format       = (sbytes_r == 3'd0);
    sts.fmt_bad         = chk_bad;
    sts.fmt_code        = chk_code;
    sts.skip_fmt_zero   = (skip_fmt_val == 32'd0);
    sts.skip_other_zero = (skip_other_val == 32'd0);
    sts.skip_last       = (skip_r == 32'd1);
    sts.div_idle        = !div_busy_r;
    sts.left_zero       = (left_r == 32'd0);
    sts.left_last       = (left_r == 32'd1);
    sts.sample_bytes    = sbytes_r;
  end

endmodule

@@ rtl/wsd_ctrl.sv @@
// parse controller: phase state machine and byte position counter
// depends on wsd_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "wave_stream_sample_decoder_core_macros.svh"

module wsd_ctrl
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic     in_start_of_file,
  input  wsd_sts_t sts,
  output logic     in_ready,
  output wsd_cmd_t cmd
);

  typedef enum logic [11:0] {
    ST_RIFF = 12'b0000_0000_0001,
    ST_SIZE = 12'b0000_0000_0010,
    ST_WAVE = 12'b0000_0000_0100,
    ST_CHDR = 12'b0000_0000_1000,
    ST_FMT  = 12'b0000_0001_0000,
    ST_SKIP = 12'b0000_0010_0000,
    ST_DATA = 12'b0000_0100_0000,
    ST_DONE = 12'b0000_1000_0000,
    ST_HALT = 12'b0001_0000_0000,
    ST_DIVA = 12'b0010_0000_0000,
    ST_DIVB = 12'b0100_0000_0000,
    ST_EMIT = 12'b1000_0000_0000
  } state_t;

  state_t     state_r, state_nxt, cur;
  logic [4:0] pos_r, pos_nxt, pos;

  // bytes are taken in every state but ST_DIVA, ST_DIVB and ST_EMIT, while the output can load
  assign in_ready = (state_r != ST_DIVA) && (state_r != ST_DIVB) &&
                    (state_r != ST_EMIT) && sts.out_free;

  assign cur = in_start_of_file ? ST_RIFF : state_r;
  assign pos = in_start_of_file ? 5'd0 : pos_r;

  always_comb begin
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (accept) begin
      state_nxt = cur;
      pos_nxt   = pos;
      unique case (cur)
        // four-byte words of the riff header
        ST_RIFF, ST_SIZE, ST_WAVE: begin
          if (pos < POS_WORD_LAST) begin
            pos_nxt = pos + 5'd1;
          end else begin
            pos_nxt = 5'd0;
            if (cur == ST_RIFF) begin
              if (!sts.riff_ok) begin
                cmd.emit       = EMIT_FAULT;
                cmd.fault_code = FLT_NOT_RIFF;
                state_nxt      = ST_HALT;
              end else begin
                state_nxt = ST_SIZE;
              end
            end else if (cur == ST_SIZE) begin
              state_nxt = ST_WAVE;
            end else if (!sts.wave_ok) begin
              cmd.emit       = EMIT_FAULT;
              cmd.fault_code = FLT_NOT_WAVE;
              state_nxt      = ST_HALT;
            end else begin
              state_nxt = ST_CHDR;
            end
          end
        end
        // chunk tag and length
        ST_CHDR: begin
          cmd.ld_tag = (pos == POS_WORD_LAST);
          if (pos < POS_CHDR_LAST) begin
            pos_nxt = pos + 5'd1;
          end else begin
            pos_nxt    = 5'd0;
            cmd.ld_len = 1'b1;
            if (sts.tag_fmt) begin
              state_nxt = ST_FMT;
            end else if (sts.tag_data) begin
              if (sts.no_format) begin
                cmd.emit       = EMIT_FAULT;
                cmd.fault_code = FLT_NO_FMT;
                state_nxt      = ST_HALT;
              end else begin
                cmd.div_len = 1'b1;
                state_nxt   = ST_DIVA;
              end
            end else begin
              cmd.skip_ld_other = 1'b1;
              state_nxt = sts.skip_other_zero ? ST_CHDR : ST_SKIP;
            end
          end
        end
        // sixteen fmt body bytes
        ST_FMT: begin
          cmd.fmt_wr   = 1'b1;
          cmd.byte_pos = pos;
          if (pos < POS_FMT_LAST) begin
            pos_nxt = pos + 5'd1;
          end else begin
            pos_nxt = 5'd0;
            if (sts.fmt_bad) begin
              cmd.emit       = EMIT_FAULT;
              cmd.fault_code = sts.fmt_code;
              state_nxt      = ST_HALT;
            end else begin
              cmd.fmt_commit  = 1'b1;
              cmd.skip_ld_fmt = 1'b1;
              state_nxt = sts.skip_fmt_zero ? ST_CHDR : ST_SKIP;
            end
          end
        end
        ST_SKIP: begin
          cmd.skip_dec = 1'b1;
          if (sts.skip_last) state_nxt = ST_CHDR;
        end
        // sample bytes
        ST_DATA: begin
          if ((pos + 5'd1) < {2'b00, sts.sample_bytes}) begin
            pos_nxt = pos + 5'd1;
          end else begin
            pos_nxt      = 5'd0;
            cmd.emit     = EMIT_SAMPLE;
            cmd.left_dec = 1'b1;
            if (sts.left_last) state_nxt = ST_DONE;
          end
        end
        default: ;
      endcase
    end else begin
      // header sequencing: two divisions then the header request
      unique case (state_r)
        ST_DIVA: begin
          if (sts.div_idle) begin
            cmd.left_ld    = 1'b1;
            cmd.div_frames = 1'b1;
            state_nxt      = ST_DIVB;
          end
        end
        ST_DIVB: begin
          if (sts.div_idle) state_nxt = ST_EMIT;
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            cmd.emit  = EMIT_HDR;
            state_nxt = sts.left_zero ? ST_DONE : ST_DATA;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RIFF;
      pos_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  `WSD_ASSERT_IMPL(a_accept_div_idle, accept, sts.div_idle, "byte taken while divider busy")
  `WSD_ASSERT_IMPL(a_hdr_out_free, cmd.emit == EMIT_HDR, sts.out_free, "header over pending request")
  `WSD_ASSERT_NEXT(a_div_len_seq, cmd.div_len, state_r == ST_DIVA, "divide start not followed")
  `WSD_ASSERT_IMPL(a_halt_quiet, (state_r == ST_HALT) && accept && !in_start_of_file, cmd.emit == EMIT_NONE, "request after fault")

endmodule

@@ rtl/wave_stream_sample_decoder_core.sv @@
// A sample or fault request is registered from the byte that completes it, valid in the cycle
// after that byte; a header request is loaded after both divisions, once the output is free.
// Throughput: one byte per cycle while the output register can load; a data chunk header
// stalls input for two 32-step serial divisions (samples, then frames) and the header emit.
// Synchronous active-low reset returns the parser to the RIFF tag and drops any request.
// top level: controller plus datapath; depends on wsd_pkg, wsd_ctrl, wsd_datapath
`timescale 1ns / 1ps

module wave_stream_sample_decoder_core
  import wsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_data_byte,
  input  logic         in_start_of_file,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_result_kind,
  output logic [1:0]   out_sample_kind,
  output logic [15:0]  out_channels,
  output logic [31:0]  out_frames_per_second,
  output logic [31:0]  out_total_frames,
  output logic signed [31:0] out_normalized_sample,
  output logic [31:0]  out_float_bits,
  output logic         out_final_sample,
  output logic [2:0]   out_fault_code
);

  wsd_cmd_t cmd;
  wsd_sts_t sts;
  logic     accept;

  // byte request taken
  assign accept = in_valid && in_ready;

  wsd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_start_of_file (in_start_of_file),
    .sts              (sts),
    .in_ready         (in_ready),
    .cmd              (cmd)
  );

  wsd_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .accept                (accept),
    .in_data_byte          (in_data_byte),
    .in_start_of_file      (in_start_of_file),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_result_kind       (out_result_kind),
    .out_sample_kind       (out_sample_kind),
    .out_channels          (out_channels),
    .out_frames_per_second (out_frames_per_second),
    .out_total_frames      (out_total_frames),
    .out_normalized_sample (out_normalized_sample),
    .out_float_bits        (out_float_bits),
    .out_final_sample      (out_final_sample),
    .out_fault_code        (out_fault_code)
  );

endmodule

@@ tb/sv/wave_stream_sample_decoder_core_checker.sv @@
// request checker for the wave stream sample decoder: predicts results per accepted byte
// and compares them in order with the output channel; depends on wsd_pkg
`timescale 1ns / 1ps

module wave_stream_sample_decoder_core_checker
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_of_file,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_result_kind,
  input  logic [1:0]         out_sample_kind,
  input  logic [15:0]        out_channels,
  input  logic [31:0]        out_frames_per_second,
  input  logic [31:0]        out_total_frames,
  input  logic signed [31:0] out_normalized_sample,
  input  logic [31:0]        out_float_bits,
  input  logic               out_final_sample,
  input  logic [2:0]         out_fault_code,
  output int                 fail_count,
  output int                 pending_count,
  output int                 header_seen,
  output int                 sample_seen,
  output int                 fault_seen
);

  typedef struct packed {
    logic [1:0]  rkind;
    logic [1:0]  skind;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] frames;
    logic [31:0] norm;
    logic [31:0] fbits;
    logic        last;
    logic [2:0]  fault;
  } wave_result_t;

  typedef enum logic [3:0] {
    P_RIFF, P_SIZE, P_WAVE, P_CHDR, P_FMT, P_SKIP, P_DATA, P_DONE, P_HALT
  } phase_t;

  wave_result_t expected_results[$];

  // parser copy
  phase_t      phase;
  logic [4:0]  pos;
  logic [31:0] shift_word, tag_word, len_word, skip_left, rate_word, samples_rem;
  logic [15:0] codec, chans, frame_sz, bits;
  logic [1:0]  kind;
  logic [2:0]  nbytes;

  function automatic logic [31:0] pad_even(logic [31:0] len, logic [31:0] minus);
    logic [32:0] r;
    r = ({1'b0, len} + 33'd1) & ~33'd1;
    r = (r > {1'b0, minus}) ? r - {1'b0, minus} : 33'd0;
    return r[32] ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [31:0] to_q30(logic [31:0] num, logic [31:0] den);
    logic [63:0] q;
    q = (({32'd0, num} << 31) + {33'd0, den[31:1]}) / {32'd0, den};
    return q[31:0] - 32'h4000_0000;
  endfunction

  task automatic clear_parser();
    phase = P_RIFF; pos = '0; shift_word = '0; tag_word = '0; len_word = '0;
    skip_left = '0; rate_word = '0; samples_rem = '0; codec = '0; chans = '0;
    frame_sz = '0; bits = '0; kind = '0; nbytes = '0;
  endtask

  task automatic push_fault(logic [2:0] code);
    wave_result_t r;
    r = '0;
    r.rkind = RES_FAULT;
    r.fault = code;
    expected_results.push_back(r);
    phase = P_HALT;
  endtask

  // one accepted byte through the parser copy
  task automatic decode_byte(logic [7:0] b, logic sof);
    wave_result_t r;
    logic [4:0]  p;
    logic [31:0] raw;
    logic [2:0]  nb;
    logic [1:0]  k;
    r = '0;
    if (sof) clear_parser();
    p = pos;
    shift_word = {b, shift_word[31:8]};
    case (phase)
      P_RIFF, P_SIZE, P_WAVE: begin
        if (p < POS_WORD_LAST) begin
          pos = p + 5'd1;
        end else begin
          pos = 0;
          if (phase == P_RIFF) begin
            if (shift_word != TAG_RIFF) push_fault(FLT_NOT_RIFF);
            else phase = P_SIZE;
          end else if (phase == P_SIZE) begin
            phase = P_WAVE;
          end else if (shift_word != TAG_WAVE) begin
            push_fault(FLT_NOT_WAVE);
          end else begin
            phase = P_CHDR;
          end
        end
      end
      P_CHDR: begin
        if (p == POS_WORD_LAST) tag_word = shift_word;
        if (p < POS_CHDR_LAST) begin
          pos = p + 5'd1;
        end else begin
          len_word = shift_word;
          pos = 0;
          if (tag_word == TAG_FMT) begin
            phase = P_FMT;
          end else if (tag_word == TAG_DATA) begin
            if (nbytes == 0) begin
              push_fault(FLT_NO_FMT);
            end else begin
              samples_rem = len_word / nbytes;
              r.rkind = RES_HEADER;
              r.skind = kind;
              r.chans = chans;
              r.rate = rate_word;
              r.frames = (chans != 0) ? samples_rem / chans : 32'd0;
              expected_results.push_back(r);
              phase = (samples_rem != 0) ? P_DATA : P_DONE;
            end
          end else begin
            skip_left = pad_even(len_word, 32'd0);
            phase = (skip_left != 0) ? P_SKIP : P_CHDR;
          end
        end
      end
      P_FMT: begin
        if (p < 2) codec[8*p[0] +: 8] = b;
        else if (p < 4) chans[8*p[0] +: 8] = b;
        else if (p < 8) rate_word[8*p[1:0] +: 8] = b;
        else if (p >= 12 && p < 14) frame_sz[8*p[0] +: 8] = b;
        else if (p >= 14) bits[8*p[0] +: 8] = b;
        if (p < POS_FMT_LAST) begin
          pos = p + 5'd1;
        end else begin
          pos = 0;
          nb = 0;
          k = KIND_U8;
          if (codec == CODEC_PCM) begin
            if (bits == 8) begin k = KIND_U8; nb = 1; end
            else if (bits <= 16) begin k = KIND_S16; nb = 2; end
            else if (bits <= 24) begin k = KIND_S24; nb = 3; end
            if (nb == 0) push_fault(FLT_PCM_BITS);
            else if (chans == 0 || 16'(nb) != frame_sz / chans) begin
              push_fault(FLT_ORG); nb = 0;
            end
          end else if (codec == CODEC_FLOAT) begin
            if (bits != 32) push_fault(FLT_FLOAT_BITS);
            else begin k = KIND_F32; nb = 4; end
          end else begin
            push_fault(FLT_CODEC);
          end
          if (nb != 0) begin
            kind = k;
            nbytes = nb;
            skip_left = pad_even(len_word, 32'd16);
            phase = (skip_left != 0) ? P_SKIP : P_CHDR;
          end
        end
      end
      P_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = P_CHDR;
      end
      P_DATA: begin
        if (p + 1 < nbytes) begin
          pos = p + 5'd1;
        end else begin
          pos = 0;
          raw = shift_word >> (8 * (4 - nbytes));
          r.rkind = RES_SAMPLE;
          r.skind = kind;
          case (kind)
            KIND_U8:  r.norm = to_q30({24'd0, raw[7:0]}, 32'd255);
            KIND_S16: r.norm = to_q30({16'd0, raw[15:0] ^ 16'h8000}, 32'd65535);
            KIND_S24: r.norm = to_q30({8'd0, raw[23:0] ^ 24'h80_0000}, 32'd16777215);
            default:  r.fbits = raw;
          endcase
          samples_rem = samples_rem - 1;
          r.last = (samples_rem == 0);
          if (samples_rem == 0) phase = P_DONE;
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // prediction and comparison at each edge
  always @(posedge clk) begin
    wave_result_t got, want;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      fail_count <= 0;
      header_seen <= 0;
      sample_seen <= 0;
      fault_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_result_kind, out_sample_kind, out_channels, out_frames_per_second,
               out_total_frames, out_normalized_sample, out_float_bits, out_final_sample,
               out_fault_code};
        case (out_result_kind)
          RES_HEADER: header_seen <= header_seen + 1;
          RES_SAMPLE: sample_seen <= sample_seen + 1;
          default:    fault_seen <= fault_seen + 1;
        endcase
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected kind %0d/%0d ch %0d rate %0d frames %0d",
                       want.rkind, want.skind, want.chans, want.rate, want.frames);
              $display("  norm %h fbits %h last %0d fault %0d",
                       want.norm, want.fbits, want.last, want.fault);
              $display("  got kind %0d/%0d ch %0d rate %0d frames %0d",
                       got.rkind, got.skind, got.chans, got.rate, got.frames);
              $display("  norm %h fbits %h last %0d fault %0d",
                       got.norm, got.fbits, got.last, got.fault);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_data_byte, in_start_of_file);
    end
    pending_count <= expected_results.size();
  end

endmodule

@@ tb/sv/wave_stream_sample_decoder_core_test.sv @@
// top of the wave stream sample decoder testbench: clock, reset, byte stimulus, verdict
// depends on wsd_pkg, wave_stream_sample_decoder_core and its checker
`timescale 1ns / 1ps

module wave_stream_sample_decoder_core_test;
  import wsd_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, in_start_of_file, out_valid, out_ready;
  logic [7:0] in_data_byte;
  logic [1:0] out_result_kind, out_sample_kind;
  logic [15:0] out_channels;
  logic [31:0] out_frames_per_second, out_total_frames, out_float_bits;
  logic signed [31:0] out_normalized_sample;
  logic out_final_sample;
  logic [2:0] out_fault_code;
  int fail_count, pending_count, header_seen, sample_seen, fault_seen;

  // one file image under construction
  logic [7:0] file_bytes[$];
  int bytes_sent;
  int idle_pct;
  bit recv_hold;
  int quiet_cycles;
  bit stim_done;

  wave_stream_sample_decoder_core dut (.*);
  wave_stream_sample_decoder_core_checker scoreboard (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  task automatic put16(int v);
    file_bytes.push_back(v[7:0]); file_bytes.push_back(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endtask

  // send the built image, first byte flagged as start of file
  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) begin
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= file_bytes[i];
      in_start_of_file <= (i == 0);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
    in_valid <= 1'b0;
    file_bytes.delete();
  endtask

  // header, optional extra chunk and fmt chunk; codec, channels, bits, frame size and fmt length chosen by caller
  task automatic build_head(int codec, int chans, int bits, int fsz, logic [31:0] fmt_len,
                            bit extra_chunk);
    int i, body;
    put32(TAG_RIFF); put32($urandom); put32(TAG_WAVE);
    if (extra_chunk) begin
      body = $urandom_range(5, 0);
      put32(32'h5453_494C); put32(body);
      for (i = 0; i < body + (body % 2); i++) file_bytes.push_back($urandom);
    end
    put32(TAG_FMT); put32(fmt_len);
    put16(codec); put16(chans); put32($urandom); put32($urandom); put16(fsz); put16(bits);
    for (i = 16; i < ((fmt_len + 1) & ~1); i++) file_bytes.push_back($urandom);
  endtask

  task automatic build_data(int len);
    int i;
    put32(TAG_DATA); put32(len);
    for (i = 0; i < len + $urandom_range(3, 0); i++) file_bytes.push_back($urandom);
  endtask

  // a well-formed file with random format and small data
  task automatic random_wave();
    int k, ch, nb, bits;
    k = $urandom_range(3, 0);
    ch = $urandom_range(3, 1);
    case (k)
      0: begin nb = 1; bits = 8; end
      1: begin nb = 2; bits = $urandom_range(1, 0) ? 16 : $urandom_range(15, 9); end
      2: begin nb = 3; bits = $urandom_range(24, 17); end
      default: begin nb = 4; bits = 32; end
    endcase
    build_head((k == 3) ? CODEC_FLOAT : CODEC_PCM, ch, bits, nb * ch,
               $urandom_range(3, 0) == 0 ? $urandom_range(21, 16) : 16, $urandom_range(1, 0));
    build_data(nb * ch * $urandom_range(6, 0) + $urandom_range(1, 0));
    send_file();
  endtask

  task automatic noise_file();
    int i, n;
    n = $urandom_range(40, 4);
    if ($urandom_range(1, 0)) begin put32(TAG_RIFF); put32($urandom); end
    for (i = 0; i < n; i++) file_bytes.push_back($urandom);
    send_file();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // receiver side: random stalls, one long hold-off
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (1) begin
      @(posedge clk);
      if (recv_hold) begin
        out_ready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk);
        recv_hold = 1'b0;
      end
      out_ready <= !(idle_pct != 0 && $urandom_range(99, 0) < idle_pct);
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || recv_hold)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000 && !stim_done) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0; in_valid = 1'b0; in_data_byte = '0; in_start_of_file = 1'b0;
    idle_pct = 23; recv_hold = 1'b0; stim_done = 1'b0; bytes_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each fault, extremes of samples, skip corners
    put32(32'h0); send_file();
    put32(TAG_RIFF); put32(32'hFFFF_FFFF); put32(32'h0); send_file();
    build_head(CODEC_PCM, 1, 25, 4, 16, 0); send_file();
    build_head(CODEC_PCM, 0, 16, 2, 16, 0); send_file();
    build_head(CODEC_PCM, 2, 16, 2, 16, 0); send_file();
    build_head(CODEC_FLOAT, 1, 24, 4, 16, 0); send_file();
    build_head(16'hFFFF, 1, 16, 2, 16, 0); send_file();
    put32(TAG_RIFF); put32(0); put32(TAG_WAVE); put32(TAG_DATA); put32(4); send_file();
    build_head(CODEC_PCM, 1, 8, 1, 16, 0); put32(TAG_DATA); put32(4);
    put32(32'hFF80_7F00); send_file();
    build_head(CODEC_PCM, 1, 4, 2, 3, 0); put32(TAG_DATA); put32(6);
    put32(32'h7FFF_8000); put16(0); send_file();
    build_head(CODEC_PCM, 1, 24, 3, 16, 0); put32(TAG_DATA); put32(6);
    put16(16'h0000); put16(16'hFF80); put16(16'h7FFF); send_file();
    build_head(CODEC_FLOAT, 0, 32, 0, 17, 1); put32(TAG_DATA); put32(8);
    put32(32'hFFFF_FFFF); put32(32'h8000_0001); send_file();
    build_head(CODEC_FLOAT, 1, 32, 4, 16, 0); put32(TAG_DATA); put32(0); send_file();
    // huge junk chunk, only its start is sent
    put32(TAG_RIFF); put32(0); put32(TAG_WAVE); put32(32'h6B6E_756A); put32(32'hFFFF_FFFF);
    for (i = 0; i < 6; i++) file_bytes.push_back(8'hA5);
    send_file();
    drain_results();

    // random: full-rate stretch, one receiver hold-off while bytes keep coming
    idle_pct = 0;
    for (i = 0; i < 6; i++) random_wave();
    recv_hold = 1'b1;
    for (i = 0; i < 4; i++) random_wave();
    drain_results();
    idle_pct = 23;
    while (bytes_sent < 1800) begin
      if ($urandom_range(9, 0) < 8) random_wave();
      else noise_file();
      if ($urandom_range(19, 0) == 0) drain_results();
    end
    drain_results();
    stim_done = 1'b1;

    $display("sent %0d bytes; checked %0d headers, %0d samples, %0d faults",
             bytes_sent, header_seen, sample_seen, fault_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
